FILE: hdl/tcqba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcqba_pkg
// Shared types and constants of the two-class transmit queue arbiter: default
// queue depths, register indexes, request and status codes, descriptor layout.
// ----------------------------------------------------------------------------
package tcqba_pkg;

	localparam int HIGH_DEPTH_DEF   = 32;
	localparam int NORMAL_DEPTH_DEF = 64;

	localparam int TAG_W  = 16;
	localparam int LEN_W  = 16;
	localparam int DESC_W = TAG_W + LEN_W;
	localparam int BURST_W = 8;
	localparam int CNT_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_HIGH_FULL = 2'd1;
	localparam status_t ST_TOO_LONG  = 2'd2;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 2'd1;

	localparam logic [BURST_W-1:0] BURST_LIMIT_RST = 8'd8;
	localparam logic [LEN_W-1:0]   MAX_LEN_RST     = 16'd1024;

endpackage

FILE: hdl/tcqba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcqba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcqba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/two_class_tx_queue_burst_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_tx_queue_burst_arbiter
// Two descriptor FIFOs (high and normal) held in RAM, strict priority on
// dequeue with a burst limit that lets a waiting normal word through.
// ----------------------------------------------------------------------------
// The block takes one request word every clock cycle; busy stays low. Each
// request gives exactly one result word, shown with done for one cycle, in the
// cycle after the request was taken; the result data comes from the registered
// read port of the descriptor RAM. The receiver cannot stall the results. The drop
// counters on the result ports hold their values after the request shown.
module two_class_tx_queue_burst_arbiter #(
	parameter int HIGH_DEPTH   = tcqba_pkg::HIGH_DEPTH_DEF,
	parameter int NORMAL_DEPTH = tcqba_pkg::NORMAL_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tcqba_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tcqba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic                            high_class,
	input  logic [tcqba_pkg::TAG_W-1:0]     packet_tag,
	input  logic [tcqba_pkg::LEN_W-1:0]     packet_length,
	output logic                            done,
	output tcqba_pkg::status_t              status,
	output logic                            replaced_oldest,
	output logic                            granted,
	output logic                            from_high,
	output logic [tcqba_pkg::TAG_W-1:0]     out_tag,
	output logic [tcqba_pkg::LEN_W-1:0]     out_length,
	output logic [tcqba_pkg::CNT_W-1:0]     high_drop_count,
	output logic [tcqba_pkg::CNT_W-1:0]     normal_drop_count
);

	import tcqba_pkg::*;

	localparam int HAW = $clog2(HIGH_DEPTH);
	localparam int HFW = $clog2(HIGH_DEPTH + 1);
	localparam int NAW = $clog2(NORMAL_DEPTH);
	localparam int NFW = $clog2(NORMAL_DEPTH + 1);

	localparam logic [HFW:0]   H_DEP_X  = (HFW+1)'(HIGH_DEPTH);
	localparam logic [HFW-1:0] H_DEP    = HFW'(HIGH_DEPTH);
	localparam logic [HAW-1:0] H_LAST   = HAW'(HIGH_DEPTH - 1);
	localparam logic [NFW:0]   N_DEP_X  = (NFW+1)'(NORMAL_DEPTH);
	localparam logic [NFW-1:0] N_DEP    = NFW'(NORMAL_DEPTH);
	localparam logic [NAW-1:0] N_LAST   = NAW'(NORMAL_DEPTH - 1);

	logic [BURST_W-1:0] burst_limit_q;
	logic [LEN_W-1:0]   max_len_q;
	logic [HAW-1:0]     high_head_q;
	logic [HFW-1:0]     high_fill_q;
	logic [NAW-1:0]     normal_head_q;
	logic [NFW-1:0]     normal_fill_q;
	logic [BURST_W-1:0] burst_run_q;
	logic [CNT_W-1:0]   high_drops_q;
	logic [CNT_W-1:0]   normal_drops_q;

	logic    done_s1;
	status_t status_s1;
	logic    replaced_s1;
	logic    granted_s1;
	logic    from_high_s1;

	logic accept;
	logic is_enq;
	logic too_long;
	logic enq_high;
	logic enq_norm;
	logic high_full;
	logic norm_full;
	logic high_ne;
	logic norm_ne;
	logic norm_by_burst;
	logic pop_high;
	logic pop_norm;
	logic adv_norm;

	logic [HFW:0]       high_sum;
	logic [HAW-1:0]     high_tail;
	logic [NFW:0]       norm_sum;
	logic [NAW-1:0]     norm_tail;
	logic [HAW-1:0]     high_head_nx;
	logic [NAW-1:0]     normal_head_nx;
	logic [DESC_W-1:0]  desc;
	logic [DESC_W-1:0]  high_rdata;
	logic [DESC_W-1:0]  norm_rdata;
	logic [DESC_W-1:0]  grant_desc;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_enq    = (req_type == REQ_ENQ);
	assign too_long  = packet_length > max_len_q;
	assign high_full = (high_fill_q == H_DEP);
	assign norm_full = (normal_fill_q == N_DEP);
	assign high_ne   = (high_fill_q != '0);
	assign norm_ne   = (normal_fill_q != '0);

	assign enq_high = accept && is_enq && !too_long && high_class;
	assign enq_norm = accept && is_enq && !too_long && !high_class;

	// After a run of burst_limit high grants a waiting normal word goes first.
	assign norm_by_burst = (burst_run_q >= burst_limit_q) && norm_ne;
	assign pop_high      = accept && !is_enq && !norm_by_burst && high_ne;
	assign pop_norm      = accept && !is_enq && (norm_by_burst || (!high_ne && norm_ne));
	// A full normal queue loses its oldest word to the new one.
	assign adv_norm      = pop_norm || (enq_norm && norm_full);

	always_comb begin
		high_sum  = {1'b0, HFW'(high_head_q)} + {1'b0, high_fill_q};
		if (high_sum >= H_DEP_X) begin
			high_sum = high_sum - H_DEP_X;
		end
		high_tail = high_sum[HAW-1:0];

		norm_sum  = {1'b0, NFW'(normal_head_q)} + {1'b0, normal_fill_q};
		if (norm_sum >= N_DEP_X) begin
			norm_sum = norm_sum - N_DEP_X;
		end
		norm_tail = norm_sum[NAW-1:0];
	end

	assign high_head_nx   = (high_head_q == H_LAST) ? '0 : high_head_q + HAW'(1);
	assign normal_head_nx = (normal_head_q == N_LAST) ? '0 : normal_head_q + NAW'(1);

	assign desc = {packet_tag, packet_length};

	tcqba_ram #(
		.WIDTH (DESC_W),
		.DEPTH (HIGH_DEPTH)
	) u_high_ram (
		.clk   (clk),
		.we    (enq_high && !high_full),
		.waddr (high_tail),
		.wdata (desc),
		.raddr (high_head_q),
		.rdata (high_rdata)
	);

	tcqba_ram #(
		.WIDTH (DESC_W),
		.DEPTH (NORMAL_DEPTH)
	) u_norm_ram (
		.clk   (clk),
		.we    (enq_norm),
		.waddr (norm_tail),
		.wdata (desc),
		.raddr (normal_head_q),
		.rdata (norm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_limit_q <= BURST_LIMIT_RST;
			max_len_q     <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BURST_LIMIT: burst_limit_q <= cfg_wdata[BURST_W-1:0];
				REG_MAX_LEN:     max_len_q     <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_head_q    <= '0;
			high_fill_q    <= '0;
			normal_head_q  <= '0;
			normal_fill_q  <= '0;
			burst_run_q    <= '0;
			high_drops_q   <= '0;
			normal_drops_q <= '0;
		end else begin
			if (enq_high && !high_full) begin
				high_fill_q <= high_fill_q + HFW'(1);
			end else if (pop_high) begin
				high_fill_q <= high_fill_q - HFW'(1);
			end
			if (pop_high) begin
				high_head_q <= high_head_nx;
			end
			if (enq_high && high_full && (high_drops_q != '1)) begin
				high_drops_q <= high_drops_q + CNT_W'(1);
			end

			if (adv_norm) begin
				normal_head_q <= normal_head_nx;
			end
			if (enq_norm && !norm_full) begin
				normal_fill_q <= normal_fill_q + NFW'(1);
			end else if (pop_norm) begin
				normal_fill_q <= normal_fill_q - NFW'(1);
			end
			if (enq_norm && norm_full && (normal_drops_q != '1)) begin
				normal_drops_q <= normal_drops_q + CNT_W'(1);
			end

			if (pop_norm) begin
				burst_run_q <= '0;
			end else if (pop_high && (burst_run_q != '1)) begin
				burst_run_q <= burst_run_q + BURST_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_enq && too_long) begin
				status_s1 <= ST_TOO_LONG;
			end else if (enq_high && high_full) begin
				status_s1 <= ST_HIGH_FULL;
			end else begin
				status_s1 <= ST_OK;
			end
			replaced_s1  <= enq_norm && norm_full;
			granted_s1   <= pop_high || pop_norm;
			from_high_s1 <= pop_high;
		end
	end

	assign grant_desc = !granted_s1 ? '0 : (from_high_s1 ? high_rdata : norm_rdata);

	assign done              = done_s1;
	assign status            = status_s1;
	assign replaced_oldest   = replaced_s1;
	assign granted           = granted_s1;
	assign from_high         = from_high_s1;
	assign out_tag           = grant_desc[DESC_W-1:LEN_W];
	assign out_length        = grant_desc[LEN_W-1:0];
	assign high_drop_count   = high_drops_q;
	assign normal_drop_count = normal_drops_q;

	a_high_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		high_fill_q <= H_DEP)
		else $error("high queue fill beyond its depth");

	a_norm_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		normal_fill_q <= N_DEP)
		else $error("normal queue fill beyond its depth");

	a_one_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop_high && pop_norm))
		else $error("both queues popped for one request");

	a_grant_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && granted |-> status == ST_OK && !replaced_oldest)
		else $error("grant word carries enqueue status");

	a_high_grant: assert property (@(posedge clk) disable iff (!arst_n)
		pop_high |=> done && granted && from_high)
		else $error("high pop not shown as a high grant");

endmodule

FILE: dv/tcqba_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcqba_result_checker
// Follows the request, result and register ports of the two-class transmit
// queue arbiter. It keeps its own copy of both descriptor queues, the burst
// run and the drop counters, works out the result of every request word taken
// and compares each result word with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module tcqba_result_checker
	import tcqba_pkg::*;
#(
	parameter int HIGH_DEPTH   = HIGH_DEPTH_DEF,
	parameter int NORMAL_DEPTH = NORMAL_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	input  logic                  busy,
	input  logic                  req_type,
	input  logic                  high_class,
	input  logic [TAG_W-1:0]      packet_tag,
	input  logic [LEN_W-1:0]      packet_length,
	input  logic                  done,
	input  status_t               status,
	input  logic                  replaced_oldest,
	input  logic                  granted,
	input  logic                  from_high,
	input  logic [TAG_W-1:0]      out_tag,
	input  logic [LEN_W-1:0]      out_length,
	input  logic [CNT_W-1:0]      high_drop_count,
	input  logic [CNT_W-1:0]      normal_drop_count,
	output int                    fail_count,
	output int                    outstanding
);

	typedef struct packed {
		status_t            status;
		logic               replaced;
		logic               granted;
		logic               from_high;
		logic [TAG_W-1:0]   tag;
		logic [LEN_W-1:0]   length;
		logic [CNT_W-1:0]   high_drops;
		logic [CNT_W-1:0]   normal_drops;
	} queue_result_t;

	logic [DESC_W-1:0]  high_desc [HIGH_DEPTH];
	logic [DESC_W-1:0]  normal_desc [NORMAL_DEPTH];
	int                 high_head;
	int                 high_fill;
	int                 normal_head;
	int                 normal_fill;
	int                 burst_run;
	logic [BURST_W-1:0] burst_limit;
	logic [LEN_W-1:0]   max_len;
	logic [CNT_W-1:0]   high_drops;
	logic [CNT_W-1:0]   normal_drops;
	queue_result_t      expected_results [$];

	function automatic logic [DESC_W-1:0] take_normal();
		logic [DESC_W-1:0] entry;
		entry = normal_desc[normal_head];
		normal_head = (normal_head + 1) % NORMAL_DEPTH;
		normal_fill--;
		return entry;
	endfunction

	function automatic queue_result_t arbitrate(input logic rq, input logic hp,
			input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
		queue_result_t     r;
		logic [DESC_W-1:0] entry;
		r = '0;
		entry = '0;
		if (rq == REQ_ENQ) begin
			// The length test wins over the class and the fill state.
			if (len > max_len) begin
				r.status = ST_TOO_LONG;
			end else if (hp) begin
				if (high_fill < HIGH_DEPTH) begin
					high_desc[(high_head + high_fill) % HIGH_DEPTH] = {tag, len};
					high_fill++;
				end else begin
					if (high_drops != '1)
						high_drops++;
					r.status = ST_HIGH_FULL;
				end
			end else begin
				if (normal_fill >= NORMAL_DEPTH) begin
					void'(take_normal());
					if (normal_drops != '1)
						normal_drops++;
					r.replaced = 1'b1;
				end
				normal_desc[(normal_head + normal_fill) % NORMAL_DEPTH] = {tag, len};
				normal_fill++;
			end
		end else begin
			if (burst_run >= burst_limit && normal_fill > 0) begin
				entry = take_normal();
				burst_run = 0;
				r.granted = 1'b1;
			end else if (high_fill > 0) begin
				entry = high_desc[high_head];
				high_head = (high_head + 1) % HIGH_DEPTH;
				high_fill--;
				if (burst_run < 255)
					burst_run++;
				r.granted = 1'b1;
				r.from_high = 1'b1;
			end else if (normal_fill > 0) begin
				entry = take_normal();
				burst_run = 0;
				r.granted = 1'b1;
			end
		end
		r.tag = entry[DESC_W-1:LEN_W];
		r.length = entry[LEN_W-1:0];
		r.high_drops = high_drops;
		r.normal_drops = normal_drops;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		queue_result_t want;
		if (!arst_n) begin
			high_head = 0;
			high_fill = 0;
			normal_head = 0;
			normal_fill = 0;
			burst_run = 0;
			burst_limit = BURST_LIMIT_RST;
			max_len = MAX_LEN_RST;
			high_drops = '0;
			normal_drops = '0;
			expected_results.delete();
		end else begin
			// The result word of the previous edge is checked before this edge's
			// request is predicted, so a stray strobe cannot claim the new word.
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("result word with no request outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, status);
					check_field("replaced_oldest", want.replaced, replaced_oldest);
					check_field("granted", want.granted, granted);
					check_field("from_high", want.from_high, from_high);
					check_field("out_tag", want.tag, out_tag);
					check_field("out_length", want.length, out_length);
					check_field("high_drop_count", want.high_drops, high_drop_count);
					check_field("normal_drop_count", want.normal_drops, normal_drop_count);
				end
			end
			// A request taken at this edge still sees the old register values.
			if (start === 1'b1 && busy === 1'b0)
				expected_results.push_back(arbitrate(req_type, high_class,
					packet_tag, packet_length));
			if (cfg_we === 1'b1) begin
				case (cfg_idx)
					REG_BURST_LIMIT: burst_limit = cfg_wdata[BURST_W-1:0];
					REG_MAX_LEN:     max_len = cfg_wdata[LEN_W-1:0];
					default: ;
				endcase
			end
		end
		outstanding = expected_results.size();
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the two-class transmit queue arbiter: a short directed pass
// over the boundaries, a long run of high grants that drives the burst run to
// its ceiling, then random phases under changing limits and sender gaps.
// ----------------------------------------------------------------------------
module tb;
	import tcqba_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  start = 1'b0;
	logic                  req_type = 1'b0;
	logic                  high_class = 1'b0;
	logic [TAG_W-1:0]      packet_tag = '0;
	logic [LEN_W-1:0]      packet_length = '0;
	logic                  busy;
	logic                  done;
	status_t               status;
	logic                  replaced_oldest;
	logic                  granted;
	logic                  from_high;
	logic [TAG_W-1:0]      out_tag;
	logic [LEN_W-1:0]      out_length;
	logic [CNT_W-1:0]      high_drop_count;
	logic [CNT_W-1:0]      normal_drop_count;
	int                    fail_count;
	int                    outstanding;
	int                    cycles = 0;
	int                    idle_pct = 0;
	logic [LEN_W-1:0]      len_limit = MAX_LEN_RST;

	two_class_tx_queue_burst_arbiter dut (.*);

	tcqba_result_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Called just after a falling edge; returns just after the falling edge that
	// follows the acceptance, with start still high.
	task automatic issue(input logic rq, input logic hp, input logic [TAG_W-1:0] tag,
			input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		high_class <= hp;
		packet_tag <= tag;
		packet_length <= len;
		forever begin
			@(posedge clk);
			if (busy === 1'b0)
				break;
		end
		@(negedge clk);
	endtask

	// The class, tag and length of a dequeue word are ignored, so they carry noise.
	task automatic pop_request();
		issue(REQ_DEQ, 1'($urandom_range(1)), TAG_W'($urandom_range(65535)),
			LEN_W'($urandom_range(65535)));
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		if ($urandom_range(99) < 85)
			return LEN_W'($urandom_range(len_limit));
		return LEN_W'($urandom_range(65535));
	endfunction

	task automatic settle();
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_MAX_LEN)
			len_limit = data;
	endtask

	task automatic run_phase(input int count, input logic [BURST_W-1:0] burst,
			input logic [LEN_W-1:0] max_len, input int enq_pct, input int high_pct,
			input int gap_pct);
		logic [7:0] junk;
		junk = 8'($urandom_range(255));
		settle();
		// The upper byte of the burst limit write must be ignored.
		write_reg(REG_BURST_LIMIT, {junk, burst});
		write_reg(REG_MAX_LEN, max_len);
		idle_pct = gap_pct;
		repeat (count) begin
			if ($urandom_range(99) < enq_pct)
				issue(REQ_ENQ, $urandom_range(99) < high_pct, TAG_W'($urandom_range(65535)),
					pick_length());
			else
				pop_request();
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Boundaries under the reset limits.
		pop_request();
		issue(REQ_ENQ, 1'b0, 16'h0000, 16'd0);
		issue(REQ_ENQ, 1'b0, 16'hFFFF, MAX_LEN_RST);
		issue(REQ_ENQ, 1'b0, 16'h1234, MAX_LEN_RST + 16'd1);
		issue(REQ_ENQ, 1'b1, 16'h5A5A, 16'hFFFF);
		issue(REQ_ENQ, 1'b1, 16'hA5A5, 16'd100);
		repeat (4) pop_request();

		// A length limit of zero lets only empty frames through; spare indexes
		// must leave both registers alone.
		settle();
		write_reg(REG_MAX_LEN, 16'd0);
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(65535)));
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom_range(65535)));
		issue(REQ_ENQ, 1'b1, 16'h0F0F, 16'd0);
		issue(REQ_ENQ, 1'b1, 16'hF0F0, 16'd1);
		issue(REQ_ENQ, 1'b0, 16'h3C3C, 16'd1);
		pop_request();

		// With a burst limit of zero a waiting normal word always goes first.
		settle();
		write_reg(REG_BURST_LIMIT, 16'hFF00);
		write_reg(REG_MAX_LEN, 16'hFFFF);
		issue(REQ_ENQ, 1'b1, 16'h1111, 16'hFFFF);
		issue(REQ_ENQ, 1'b0, 16'h2222, 16'h8000);
		issue(REQ_ENQ, 1'b1, 16'h3333, 16'd7);
		repeat (4) pop_request();

		// More than 255 high grants in a row: the burst run must stick at its
		// ceiling, so a normal word arriving afterwards is served first.
		settle();
		write_reg(REG_BURST_LIMIT, 16'h00FF);
		write_reg(REG_MAX_LEN, MAX_LEN_RST);
		idle_pct = 9;
		repeat (100) pop_request();
		repeat (270) begin
			issue(REQ_ENQ, 1'b1, TAG_W'($urandom_range(65535)),
				LEN_W'($urandom_range(MAX_LEN_RST)));
			pop_request();
		end
		issue(REQ_ENQ, 1'b0, TAG_W'($urandom_range(65535)), LEN_W'($urandom_range(MAX_LEN_RST)));
		issue(REQ_ENQ, 1'b1, TAG_W'($urandom_range(65535)), LEN_W'($urandom_range(MAX_LEN_RST)));
		repeat (3) pop_request();

		run_phase(150, 8'd1, 16'hFFFF, 50, 50, 0);
		run_phase(150, 8'd3, 16'd1024, 80, 70, 67);
		run_phase(150, 8'd255, 16'd2000, 25, 50, 0);
		run_phase(200, 8'd0, 16'd500, 80, 20, 9);
		run_phase(150, 8'd8, 16'd1, 50, 50, 67);
		run_phase(150, 8'd2, 16'hFFFF, 60, 60, 0);
		run_phase(150, 8'd255, 16'd1024, 70, 40, 9);
		run_phase(150, 8'd5, 16'd0, 50, 50, 67);

		settle();
		repeat (4) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
